>>> sv/vtbb_pkg.sv
// ----------------------------------------------------------------------------
// vtbb_pkg: shared types and helpers for the vertex transform block
// Holds the fixed-point widths, the beat structs of both channels, the
// configuration view and the rounding and saturation helpers.
// ----------------------------------------------------------------------------
package vtbb_pkg;

  localparam int CoordW    = 32;
  localparam int FracW     = 16;
  localparam int EntryW    = 32;
  localparam int ScaleW    = 31;
  localparam int RegW      = 64;
  localparam int AddrW     = 6;
  localparam int NumMatReg = 6;
  localparam int ProdW     = CoordW + EntryW;
  localparam int AccW      = ProdW - FracW + 2;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  localparam logic [RegW-1:0]   Row0Cols01Rst = RegW'(64'd65536);
  localparam logic [RegW-1:0]   Row0Cols23Rst = '0;
  localparam logic [RegW-1:0]   Row1Cols01Rst = RegW'(64'd281474976710656);
  localparam logic [RegW-1:0]   Row1Cols23Rst = '0;
  localparam logic [RegW-1:0]   Row2Cols01Rst = '0;
  localparam logic [RegW-1:0]   Row2Cols23Rst = RegW'(64'd65536);
  localparam logic [ScaleW-1:0] SimScaleRst   = ScaleW'(32'd65536);

  typedef enum logic [2:0] {
    RegRow0Cols01 = 3'd0,
    RegRow0Cols23 = 3'd1,
    RegRow1Cols01 = 3'd2,
    RegRow1Cols23 = 3'd3,
    RegRow2Cols01 = 3'd4,
    RegRow2Cols23 = 3'd5,
    RegSimScale   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic signed [CoordW-1:0] vertex_z;
    logic                     last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic signed [CoordW-1:0] box_min_x;
    logic signed [CoordW-1:0] box_min_y;
    logic signed [CoordW-1:0] box_min_z;
    logic signed [CoordW-1:0] box_max_x;
    logic signed [CoordW-1:0] box_max_y;
    logic signed [CoordW-1:0] box_max_z;
    logic                     last_result;
  } result_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] coord;
    logic                   last;
  } scaled_t;

  typedef struct packed {
    logic [2:0][2:0][EntryW-1:0] m;
    logic [2:0][EntryW-1:0]      t;
    logic [ScaleW-1:0]           scale;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Floor division of a product by 2^FracW, kept at accumulator width.
  function automatic logic signed [AccW-1:0] floor_prod(logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p >>> FracW;
    return s[AccW-1:0];
  endfunction

  // Clamp an accumulator value to the signed coordinate range.
  function automatic logic signed [CoordW-1:0] sat_coord(logic signed [AccW-1:0] a);
    logic signed [CoordW-1:0] r;
    if (&a[AccW-1:CoordW-1] || ~|a[AccW-1:CoordW-1]) begin
      r = a[CoordW-1:0];
    end else if (a[AccW-1]) begin
      r = CoordMin;
    end else begin
      r = CoordMax;
    end
    return r;
  endfunction

endpackage

>>> sv/vtbb_front.sv
// ----------------------------------------------------------------------------
// vtbb_front: vertex intake and uniform scale
// Accepts vertex beats, multiplies each coordinate by the scale, then rounds
// down and saturates the products before handing them to the queue.
// ----------------------------------------------------------------------------
module vtbb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  vtbb_pkg::vertex_t           in_data_i,
  input  logic [vtbb_pkg::ScaleW-1:0] scale_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output vtbb_pkg::scaled_t           push_data_o
);

  logic                                 s1_valid_q;
  logic                                 last_q;
  logic signed [vtbb_pkg::ProdW-1:0]    prod_q [3];
  logic signed [vtbb_pkg::ProdW-1:0]    prod_d [3];
  logic signed [vtbb_pkg::ScaleW:0]     scale_s;
  logic                                 accept;

  assign in_ready_o = !s1_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    scale_s   = $signed({1'b0, scale_i});
    prod_d[0] = in_data_i.vertex_x * scale_s;
    prod_d[1] = in_data_i.vertex_y * scale_s;
    prod_d[2] = in_data_i.vertex_z * scale_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
      last_q <= in_data_i.last_vertex;
    end
  end

  always_comb begin
    push_valid_o = s1_valid_q;
    for (int i = 0; i < 3; i++) begin
      push_data_o.coord[i] = vtbb_pkg::sat_coord(vtbb_pkg::floor_prod(prod_q[i]));
    end
    push_data_o.last = last_q;
  end

endmodule

>>> sv/vtbb_fifo.sv
// ----------------------------------------------------------------------------
// vtbb_fifo: short queue between the front and the back
// Holds scaled vertices so that intake and transform can stall separately.
// ----------------------------------------------------------------------------
module vtbb_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  vtbb_pkg::scaled_t    push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output vtbb_pkg::scaled_t    pop_data_o,
  output vtbb_pkg::fifo_stat_t stat_o
);

  vtbb_pkg::scaled_t                 mem_q [vtbb_pkg::FifoDepth];
  logic [vtbb_pkg::FifoPtrW-1:0]     wr_ptr_q;
  logic [vtbb_pkg::FifoPtrW-1:0]     rd_ptr_q;
  logic [vtbb_pkg::FifoCntW-1:0]     cnt_q;
  logic                              push;
  logic                              pop;

  assign stat_o.full  = (cnt_q == vtbb_pkg::FifoCntW'(vtbb_pkg::FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign push_ready_o = !stat_o.full;
  assign pop_valid_o  = !stat_o.empty;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == vtbb_pkg::FifoPtrW'(vtbb_pkg::FifoDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == vtbb_pkg::FifoPtrW'(vtbb_pkg::FifoDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/vtbb_back.sv
// ----------------------------------------------------------------------------
// vtbb_back: matrix transform and running bounding box
// Three stages: nine matrix products, the rounded sum with translation and
// saturation, then the box update into the output register.
// ----------------------------------------------------------------------------
module vtbb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vtbb_pkg::cfg_t    cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  vtbb_pkg::scaled_t pop_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vtbb_pkg::result_t out_data_o
);

  logic                               p_valid_q;
  logic                               p_last_q;
  logic signed [vtbb_pkg::ProdW-1:0]  prod_q [3][3];
  logic signed [vtbb_pkg::ProdW-1:0]  prod_d [3][3];
  logic                               a_valid_q;
  logic                               a_last_q;
  logic signed [vtbb_pkg::CoordW-1:0] res_q [3];
  logic signed [vtbb_pkg::CoordW-1:0] res_d [3];
  logic signed [vtbb_pkg::AccW-1:0]   acc [3];
  logic signed [vtbb_pkg::CoordW-1:0] min_q [3];
  logic signed [vtbb_pkg::CoordW-1:0] max_q [3];
  logic signed [vtbb_pkg::CoordW-1:0] min_d [3];
  logic signed [vtbb_pkg::CoordW-1:0] max_d [3];
  logic                               out_valid_q;
  vtbb_pkg::result_t                  out_q;
  logic                               p_adv;
  logic                               a_adv;
  logic                               b_adv;

  assign b_adv       = a_valid_q && (!out_valid_q || out_ready_i);
  assign a_adv       = p_valid_q && (!a_valid_q || b_adv);
  assign pop_ready_o = !p_valid_q || a_adv;
  assign p_adv       = pop_valid_i && pop_ready_o;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(cfg_i.m[r][c]) * $signed(pop_data_i.coord[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = vtbb_pkg::AccW'($signed(cfg_i.t[r]))
             + vtbb_pkg::floor_prod(prod_q[r][0])
             + vtbb_pkg::floor_prod(prod_q[r][1])
             + vtbb_pkg::floor_prod(prod_q[r][2]);
      res_d[r] = vtbb_pkg::sat_coord(acc[r]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      min_d[r] = (res_q[r] < min_q[r]) ? res_q[r] : min_q[r];
      max_d[r] = (res_q[r] > max_q[r]) ? res_q[r] : max_q[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        min_q[r] <= vtbb_pkg::CoordMax;
        max_q[r] <= vtbb_pkg::CoordMin;
      end
    end else begin
      if (p_adv) begin
        p_valid_q <= 1'b1;
      end else if (a_adv) begin
        p_valid_q <= 1'b0;
      end
      if (a_adv) begin
        a_valid_q <= 1'b1;
      end else if (b_adv) begin
        a_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (b_adv) begin
        for (int r = 0; r < 3; r++) begin
          min_q[r] <= a_last_q ? vtbb_pkg::CoordMax : min_d[r];
          max_q[r] <= a_last_q ? vtbb_pkg::CoordMin : max_d[r];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_adv) begin
      prod_q   <= prod_d;
      p_last_q <= pop_data_i.last;
    end
    if (a_adv) begin
      res_q    <= res_d;
      a_last_q <= p_last_q;
    end
    if (b_adv) begin
      out_q.out_x       <= res_q[0];
      out_q.out_y       <= res_q[1];
      out_q.out_z       <= res_q[2];
      out_q.box_min_x   <= min_d[0];
      out_q.box_min_y   <= min_d[1];
      out_q.box_min_z   <= min_d[2];
      out_q.box_max_x   <= max_d[0];
      out_q.box_max_y   <= max_d[1];
      out_q.box_max_z   <= max_d[2];
      out_q.last_result <= a_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/vertex_transform_bounding_box.sv
// ----------------------------------------------------------------------------
// vertex_transform_bounding_box: affine vertex transform with running box
// Scales each vertex, applies a 3x4 affine matrix and tracks the mesh bounds.
// ----------------------------------------------------------------------------
// The block takes one vertex per cycle while it is not stalled and returns one
// result beat per vertex once it has passed the front register, the queue and
// the back stages. The throughput of one vertex per cycle is set by the three
// scale multipliers in the front and the nine matrix multipliers in the back,
// each followed by a register. A two-entry queue sits between front and back,
// so the front keeps taking vertices for a while when results are not taken.
// Every result carries the bounding box including its own vertex; the box
// restarts empty after a vertex marked last. Registers are 64 bits wide at
// byte address 8*i and must be written only while the block is idle.
// ----------------------------------------------------------------------------
module vertex_transform_bounding_box (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  vtbb_pkg::vertex_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output vtbb_pkg::result_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vtbb_pkg::AddrW-1:0]  paddr,
  input  logic [vtbb_pkg::RegW-1:0]   pwdata,
  output logic [vtbb_pkg::RegW-1:0]   prdata,
  output logic                        pready
);

  logic [vtbb_pkg::RegW-1:0]   mat_q [vtbb_pkg::NumMatReg];
  logic [vtbb_pkg::ScaleW-1:0] scale_q;
  vtbb_pkg::reg_idx_e          reg_idx;
  vtbb_pkg::cfg_t              cfg;
  logic                        cfg_wr;
  logic                        push_valid;
  logic                        push_ready;
  vtbb_pkg::scaled_t           push_data;
  logic                        pop_valid;
  logic                        pop_ready;
  vtbb_pkg::scaled_t           pop_data;
  vtbb_pkg::fifo_stat_t        fifo_stat;

  assign pready  = 1'b1;
  assign reg_idx = vtbb_pkg::reg_idx_e'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= vtbb_pkg::Row0Cols01Rst;
      mat_q[1] <= vtbb_pkg::Row0Cols23Rst;
      mat_q[2] <= vtbb_pkg::Row1Cols01Rst;
      mat_q[3] <= vtbb_pkg::Row1Cols23Rst;
      mat_q[4] <= vtbb_pkg::Row2Cols01Rst;
      mat_q[5] <= vtbb_pkg::Row2Cols23Rst;
      scale_q  <= vtbb_pkg::SimScaleRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        vtbb_pkg::RegRow0Cols01: mat_q[0] <= pwdata;
        vtbb_pkg::RegRow0Cols23: mat_q[1] <= pwdata;
        vtbb_pkg::RegRow1Cols01: mat_q[2] <= pwdata;
        vtbb_pkg::RegRow1Cols23: mat_q[3] <= pwdata;
        vtbb_pkg::RegRow2Cols01: mat_q[4] <= pwdata;
        vtbb_pkg::RegRow2Cols23: mat_q[5] <= pwdata;
        vtbb_pkg::RegSimScale:   scale_q  <= pwdata[vtbb_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      vtbb_pkg::RegRow0Cols01: prdata = mat_q[0];
      vtbb_pkg::RegRow0Cols23: prdata = mat_q[1];
      vtbb_pkg::RegRow1Cols01: prdata = mat_q[2];
      vtbb_pkg::RegRow1Cols23: prdata = mat_q[3];
      vtbb_pkg::RegRow2Cols01: prdata = mat_q[4];
      vtbb_pkg::RegRow2Cols23: prdata = mat_q[5];
      vtbb_pkg::RegSimScale:   prdata = vtbb_pkg::RegW'(scale_q);
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cfg.m[r][0] = mat_q[2*r][vtbb_pkg::EntryW-1:0];
      cfg.m[r][1] = mat_q[2*r][2*vtbb_pkg::EntryW-1:vtbb_pkg::EntryW];
      cfg.m[r][2] = mat_q[2*r+1][vtbb_pkg::EntryW-1:0];
      cfg.t[r]    = mat_q[2*r+1][2*vtbb_pkg::EntryW-1:vtbb_pkg::EntryW];
    end
    cfg.scale = scale_q;
  end

  vtbb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .scale_i      (cfg.scale),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  vtbb_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data),
    .stat_o       (fifo_stat)
  );

  vtbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_fifo_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("Queue reports full and empty at once.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> fifo_stat.full)
    else $error("Intake stalled while the queue had room.");

  a_point_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.box_min_x <= out_data_o.out_x) &&
      (out_data_o.out_x <= out_data_o.box_max_x) &&
      (out_data_o.box_min_y <= out_data_o.out_y) &&
      (out_data_o.out_y <= out_data_o.box_max_y) &&
      (out_data_o.box_min_z <= out_data_o.out_z) &&
      (out_data_o.out_z <= out_data_o.box_max_z))
    else $error("Result vertex lies outside its bounding box.");

endmodule
